/* src/assert_macros.svh */
// Assertion macros shared by the RTL; bodies drop out in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while in reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, sampled on clk, off while in reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/hpt_comp_pkg.sv */
// Package: constants, register indexes and the side-band struct of the pipeline.
package hpt_comp_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TEMP       = 3'd0;
    localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] CFG_PRESS_LAST = 3'd3;
    localparam logic [2:0] CFG_HUM        = 3'd4;
    localparam logic [2:0] CFG_HUM_MID    = 3'd5;

    // Pipeline geometry
    localparam int FrontStages = 11;
    localparam int NumDiv      = 64;
    localparam int PostStages  = 6;
    localparam int NumStages   = FrontStages + NumDiv + PostStages;
    localparam int RemW        = 30;

    // Formula constants
    localparam logic signed [32:0] PressTfOffset = 33'sd128000;
    localparam logic [20:0]        PressBase     = 21'd1048576;
    localparam logic [63:0]        PressScale    = 64'd3125;
    localparam logic [63:0]        PressHalf     = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        TempRound     = 32'd128;
    localparam logic [31:0]        HumTfOffset   = 32'd76800;
    localparam logic [31:0]        HumMax        = 32'd419430400;
    localparam logic [31:0]        HumRound      = 32'd16384;
    localparam logic [31:0]        HumBias       = 32'd2097152;
    localparam logic [31:0]        HumRound2     = 32'd8192;
    localparam logic [31:0]        HumBias2      = 32'd32768;
    localparam logic [16:0]        HumOutMax     = 17'd102400;

    // Results that ride along with the pressure division
    typedef struct packed {
        logic [31:0] tf;
        logic [23:0] temp;
        logic [16:0] hum;
        logic        neg;
        logic        zero;
    } side_t;

endpackage

/* src/humidity_pressure_temp_compensation_top.sv */
// Top level: pipelined integer temperature, pressure and humidity compensation.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_ready  | raw_temperature, raw_pressure, raw_humidity
//  output   | out_valid / out_ready| fine_temperature, temperature_centideg,
//           |                      | pressure_q24_8, pressure_invalid, humidity_q22_10
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready holds; 81 register stages: 11 front
// stages (input capture, then arithmetic), a 64-stage restoring divider (one quotient
// bit per stage) and 6 stages after it.
// Reset clears all valid bits and the calibration registers.
// A stalled output freezes the pipeline; the entry stage still takes a beat when empty.
`include "assert_macros.svh"

module humidity_pressure_temp_compensation_top
    import hpt_comp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] raw_temperature,
    input  logic [19:0] raw_pressure,
    input  logic [15:0] raw_humidity,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] fine_temperature,
    output logic signed [23:0] temperature_centideg,
    output logic [31:0] pressure_q24_8,
    output logic        pressure_invalid,
    output logic [16:0] humidity_q22_10,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // ---------------- calibration registers ----------------
    logic [47:0] temp_cal_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_last_reg;
    logic [39:0] hum_cal_reg;
    logic [23:0] hum_mid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_last_reg <= '0;
            hum_cal_reg    <= '0;
            hum_mid_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TEMP:       temp_cal_reg   <= cfg_data[47:0];
                CFG_PRESS_LOW:  press_lo_reg   <= cfg_data;
                CFG_PRESS_HIGH: press_hi_reg   <= cfg_data;
                CFG_PRESS_LAST: press_last_reg <= cfg_data[15:0];
                CFG_HUM:        hum_cal_reg    <= cfg_data[39:0];
                CFG_HUM_MID:    hum_mid_reg    <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // coefficient fields
    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic [15:0]        p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0]         h1, h3, h6;
    logic [15:0]        h2;
    logic [11:0]        h4, h5;

    assign t1 = temp_cal_reg[15:0];
    assign t2 = temp_cal_reg[31:16];
    assign t3 = temp_cal_reg[47:32];
    assign p1 = press_lo_reg[15:0];
    assign p2 = press_lo_reg[31:16];
    assign p3 = press_lo_reg[47:32];
    assign p4 = press_lo_reg[63:48];
    assign p5 = press_hi_reg[15:0];
    assign p6 = press_hi_reg[31:16];
    assign p7 = press_hi_reg[47:32];
    assign p8 = press_hi_reg[63:48];
    assign p9 = press_last_reg;
    assign h1 = hum_cal_reg[7:0];
    assign h2 = hum_cal_reg[23:8];
    assign h3 = hum_cal_reg[31:24];
    assign h6 = hum_cal_reg[39:32];
    assign h4 = hum_mid_reg[11:0];
    assign h5 = hum_mid_reg[23:12];

    // ---------------- pipeline control ----------------
    logic [NumStages-1:0] vld_reg;
    logic                 adv;

    assign adv       = !vld_reg[NumStages-1] || out_ready;
    assign in_ready  = adv || !vld_reg[0];
    assign out_valid = vld_reg[NumStages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv)
            begin
                vld_reg[NumStages-1:1] <= vld_reg[NumStages-2:0];
            end
        end
    end

    // ---------------- stage 0: input beat ----------------
    logic [19:0] rt0_reg, rp0_reg;
    logic [15:0] rh0_reg;

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            rt0_reg <= raw_temperature;
            rp0_reg <= raw_pressure;
            rh0_reg <= raw_humidity;
        end
    end

    // ---------------- stage 1: temperature products ----------------
    logic signed [17:0] a1;
    logic signed [16:0] d1;
    logic signed [33:0] at2_next, dd_next;
    logic [31:0] at2_reg, dd_reg;
    logic [19:0] rp1_reg;
    logic [15:0] rh1_reg;

    assign a1       = $signed({1'b0, rt0_reg[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign d1       = $signed({1'b0, rt0_reg[19:4]}) - $signed({1'b0, t1});
    assign at2_next = a1 * t2;
    assign dd_next  = d1 * d1;

    // ---------------- stage 2: T3 term ----------------
    logic signed [31:0] v1t_next, dd_s;
    logic signed [19:0] g2;
    logic signed [35:0] gt3_next;
    logic [31:0] v1t_reg, gt3_reg;
    logic [19:0] rp2_reg;
    logic [15:0] rh2_reg;

    assign v1t_next = $signed(at2_reg) >>> 11;
    assign dd_s     = $signed(dd_reg) >>> 12;
    assign g2       = dd_s[19:0];
    assign gt3_next = g2 * t3;

    // ---------------- stage 3: fine temperature ----------------
    logic signed [31:0] gt3_s;
    logic [31:0] tf_next, tf3_reg;
    logic [19:0] rp3_reg;
    logic [15:0] rh3_reg;

    assign gt3_s   = $signed(gt3_reg) >>> 14;
    assign tf_next = v1t_reg + gt3_s;

    // ---------------- stage 4: offsets and temperature ----------------
    logic signed [32:0] w1_next, w1_reg;
    logic [31:0] t5;
    logic signed [31:0] t5_s;
    logic [31:0] x_next, x4_reg;
    logic [19:0] rp4_reg;
    logic [15:0] rh4_reg;
    logic [31:0] tf_reg [4:9];
    logic [23:0] temp_reg [4:9];

    assign w1_next = $signed({tf3_reg[31], tf3_reg}) - PressTfOffset;
    assign t5      = tf3_reg + {tf3_reg[29:0], 2'b00} + TempRound;
    assign t5_s    = $signed(t5) >>> 8;
    assign x_next  = tf3_reg - HumTfOffset;

    // ---------------- stage 5: pressure squares, humidity start ----------------
    logic signed [65:0] ww_p;
    logic signed [48:0] wp5_p, wp2_p;
    logic [31:0] h5x, ha_sum, hb_next, hc_next;
    logic signed [31:0] ha_next;
    logic [63:0] ww5_reg;
    logic [48:0] wp5_5_reg, wp2_5_reg;
    logic [31:0] ha5_reg, hbp5_reg, hcp5_reg;
    logic [19:0] rp5_reg;

    assign ww_p    = w1_reg * w1_reg;
    assign wp5_p   = w1_reg * $signed(p5);
    assign wp2_p   = w1_reg * $signed(p2);
    assign h5x     = x4_reg * {{20{h5[11]}}, h5};
    assign ha_sum  = {2'b00, rh4_reg, 14'b0} - {h4, 20'b0} - h5x + HumRound;
    assign ha_next = $signed(ha_sum) >>> 15;
    assign hb_next = x4_reg * {{24{h6[7]}}, h6};
    assign hc_next = x4_reg * {24'b0, h3};

    // ---------------- stage 6: P6 and P3 terms ----------------
    logic [63:0] w2a_next, w1a_next;
    logic signed [31:0] hb_s, hc_s;
    logic [31:0] hc_v, hbc_next;
    logic [63:0] w2a6_reg, w1a6_reg;
    logic [48:0] wp5_6_reg, wp2_6_reg;
    logic [31:0] ha6_reg, hbc6_reg;
    logic [19:0] rp6_reg;

    assign w2a_next = ww5_reg * {{48{p6[15]}}, p6};
    assign w1a_next = ww5_reg * {{48{p3[15]}}, p3};
    assign hb_s     = $signed(hbp5_reg) >>> 10;
    assign hc_s     = $signed(hcp5_reg) >>> 11;
    assign hc_v     = hc_s + HumBias2;
    assign hbc_next = hb_s * hc_v;

    // ---------------- stage 7: var2 and var1 sums ----------------
    logic signed [63:0] w1a_s;
    logic [63:0] w2_next, s_next;
    logic signed [31:0] hbc_s;
    logic [31:0] he, heh2_next;
    logic [63:0] w2_7_reg, s7_reg;
    logic [31:0] ha7_reg, heh2_7_reg;
    logic [19:0] rp7_reg;

    assign w2_next   = w2a6_reg + ({{15{wp5_6_reg[48]}}, wp5_6_reg} << 17)
                     + ({{48{p4[15]}}, p4} << 35);
    assign w1a_s     = $signed(w1a6_reg) >>> 8;
    assign s_next    = w1a_s + ({{15{wp2_6_reg[48]}}, wp2_6_reg} << 12) + PressHalf;
    assign hbc_s     = $signed(hbc6_reg) >>> 10;
    assign he        = hbc_s + HumBias;
    assign heh2_next = he * {{16{h2[15]}}, h2};

    // ---------------- stage 8: P1 scaling, dividend start ----------------
    logic [63:0] sp1_next, pn_next;
    logic [20:0] pb;
    logic [31:0] hfs, vh_next;
    logic signed [31:0] hf;
    logic [63:0] sp1_8_reg, pn8_reg;
    logic [31:0] vh8_reg;

    assign sp1_next = s7_reg * {48'b0, p1};
    assign pb       = PressBase - {1'b0, rp7_reg};
    assign pn_next  = {12'b0, pb, 31'b0} - w2_7_reg;
    assign hfs      = heh2_7_reg + HumRound2;
    assign hf       = $signed(hfs) >>> 14;
    assign vh_next  = ha7_reg * hf;

    // ---------------- stage 9: dividend, divisor ----------------
    logic [63:0] n_next;
    logic signed [31:0] g9;
    logic [31:0] gg_next;
    logic [63:0] n9_reg;
    logic [30:0] d9_reg;
    logic [31:0] vh9_reg, gg9_reg;

    assign n_next  = pn8_reg * PressScale;
    assign g9      = $signed(vh8_reg) >>> 15;
    assign gg_next = g9 * g9;

    // ---------------- stage 10: magnitudes, humidity finish ----------------
    logic [63:0] mn_next, mn10_reg;
    logic [30:0] md_next, md10_reg;
    logic signed [31:0] gg_s, gh_s;
    logic [31:0] gh, vv;
    logic [16:0] hum_next;
    side_t side_next, side10_reg;

    assign mn_next = n9_reg[63] ? (64'd0 - n9_reg) : n9_reg;
    assign md_next = d9_reg[30] ? (31'd0 - d9_reg) : d9_reg;
    assign gg_s    = $signed(gg9_reg) >>> 7;
    assign gh      = gg_s * {24'b0, h1};
    assign gh_s    = $signed(gh) >>> 4;
    assign vv      = vh9_reg - gh_s;

    // clamp to 0..100 %RH before the final shift
    always_comb
    begin
        if (vv[31])
        begin
            hum_next = '0;
        end
        else if (vv > HumMax)
        begin
            hum_next = HumMax[28:12];
        end
        else
        begin
            hum_next = vv[28:12];
        end
        side_next.tf   = tf_reg[9];
        side_next.temp = temp_reg[9];
        side_next.hum  = hum_next;
        side_next.neg  = n9_reg[63] ^ d9_reg[30];
        side_next.zero = (d9_reg == '0);
    end

    // front stage registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            at2_reg  <= at2_next[31:0];
            dd_reg   <= dd_next[31:0];
            rp1_reg  <= rp0_reg;
            rh1_reg  <= rh0_reg;

            v1t_reg  <= v1t_next;
            gt3_reg  <= gt3_next[31:0];
            rp2_reg  <= rp1_reg;
            rh2_reg  <= rh1_reg;

            tf3_reg  <= tf_next;
            rp3_reg  <= rp2_reg;
            rh3_reg  <= rh2_reg;

            w1_reg      <= w1_next;
            x4_reg      <= x_next;
            tf_reg[4]   <= tf3_reg;
            temp_reg[4] <= t5_s[23:0];
            rp4_reg     <= rp3_reg;
            rh4_reg     <= rh3_reg;
            for (int i = 5; i <= 9; i++)
            begin
                tf_reg[i]   <= tf_reg[i-1];
                temp_reg[i] <= temp_reg[i-1];
            end

            ww5_reg   <= ww_p[63:0];
            wp5_5_reg <= wp5_p;
            wp2_5_reg <= wp2_p;
            ha5_reg   <= ha_next;
            hbp5_reg  <= hb_next;
            hcp5_reg  <= hc_next;
            rp5_reg   <= rp4_reg;

            w2a6_reg  <= w2a_next;
            w1a6_reg  <= w1a_next;
            wp5_6_reg <= wp5_5_reg;
            wp2_6_reg <= wp2_5_reg;
            ha6_reg   <= ha5_reg;
            hbc6_reg  <= hbc_next;
            rp6_reg   <= rp5_reg;

            w2_7_reg   <= w2_next;
            s7_reg     <= s_next;
            ha7_reg    <= ha6_reg;
            heh2_7_reg <= heh2_next;
            rp7_reg    <= rp6_reg;

            sp1_8_reg <= sp1_next;
            pn8_reg   <= pn_next;
            vh8_reg   <= vh_next;

            n9_reg  <= n_next;
            d9_reg  <= sp1_8_reg[63:33];
            vh9_reg <= vh8_reg;
            gg9_reg <= gg_next;

            mn10_reg   <= mn_next;
            md10_reg   <= md_next;
            side10_reg <= side_next;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    logic [63:0]     dq_reg  [NumDiv];
    logic [RemW-1:0] rem_reg [NumDiv];
    logic [30:0]     md_reg  [NumDiv];
    side_t           sd_reg  [NumDiv];
    logic [63:0]     dq_in   [NumDiv];
    logic [RemW-1:0] rem_in  [NumDiv];
    logic [30:0]     md_in   [NumDiv];
    side_t           sd_in   [NumDiv];
    logic [RemW:0]   trial   [NumDiv];
    logic [RemW:0]   diff    [NumDiv];
    logic            ge      [NumDiv];

    always_comb
    begin
        dq_in[0]  = mn10_reg;
        rem_in[0] = '0;
        md_in[0]  = md10_reg;
        sd_in[0]  = side10_reg;
        for (int k = 1; k < NumDiv; k++)
        begin
            dq_in[k]  = dq_reg[k-1];
            rem_in[k] = rem_reg[k-1];
            md_in[k]  = md_reg[k-1];
            sd_in[k]  = sd_reg[k-1];
        end
        for (int k = 0; k < NumDiv; k++)
        begin
            trial[k] = {rem_in[k], dq_in[k][63]};
            diff[k]  = trial[k] - md_in[k];
            ge[k]    = (trial[k] >= md_in[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NumDiv; k++)
            begin
                dq_reg[k]  <= {dq_in[k][62:0], ge[k]};
                rem_reg[k] <= ge[k] ? diff[k][RemW-1:0] : trial[k][RemW-1:0];
                md_reg[k]  <= md_in[k];
                sd_reg[k]  <= sd_in[k];
            end
        end
    end

    // ---------------- post-division correction ----------------
    side_t       sdp_reg [PostStages];
    logic [63:0] q, pa_next, pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [63:0] ps;
    logic [63:0] ll_next, e2p_next, ll_reg, e2p_reg;
    logic [31:0] lh_next, lh_reg;
    logic [63:0] sq_next, sq_reg, e1p_next, e1p_reg, sum_next, sum_reg;
    logic signed [63:0] e2_s, e1_s, sum_s;
    logic [63:0] e2_reg, e2b_reg, pf;
    logic [31:0] pres_next, pres_reg;

    assign q        = dq_reg[NumDiv-1];
    assign pa_next  = sd_reg[NumDiv-1].neg ? (64'd0 - q) : q;
    assign ps       = $signed(pa_reg) >>> 13;
    assign ll_next  = 64'(ps[31:0]) * 64'(ps[31:0]);
    assign lh_next  = ps[31:0] * ps[63:32];
    assign e2p_next = pa_reg * {{48{p8[15]}}, p8};
    assign sq_next  = ll_reg + {lh_reg[30:0], 33'b0};
    assign e2_s     = $signed(e2p_reg) >>> 19;
    assign e1p_next = sq_reg * {{48{p9[15]}}, p9};
    assign e1_s     = $signed(e1p_reg) >>> 25;
    assign sum_next = pd_reg + e1_s + e2b_reg;
    assign sum_s    = $signed(sum_reg) >>> 8;
    assign pf       = sum_s + ({{48{p7[15]}}, p7} << 4);

    // saturate to the unsigned 32-bit field; a zero divisor forces 0
    always_comb
    begin
        if (sdp_reg[4].zero || pf[63])
        begin
            pres_next = '0;
        end
        else if (pf[63:32] != '0)
        begin
            pres_next = '1;
        end
        else
        begin
            pres_next = pf[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg     <= pa_next;
            sdp_reg[0] <= sd_reg[NumDiv-1];

            ll_reg     <= ll_next;
            lh_reg     <= lh_next;
            e2p_reg    <= e2p_next;
            pb_reg     <= pa_reg;

            sq_reg     <= sq_next;
            e2_reg     <= e2_s;
            pc_reg     <= pb_reg;

            e1p_reg    <= e1p_next;
            e2b_reg    <= e2_reg;
            pd_reg     <= pc_reg;

            sum_reg    <= sum_next;

            pres_reg   <= pres_next;
            for (int i = 1; i < PostStages; i++)
            begin
                sdp_reg[i] <= sdp_reg[i-1];
            end
        end
    end

    // ---------------- output beat ----------------
    assign fine_temperature     = sdp_reg[PostStages-1].tf;
    assign temperature_centideg = sdp_reg[PostStages-1].temp;
    assign pressure_q24_8       = pres_reg;
    assign pressure_invalid     = sdp_reg[PostStages-1].zero;
    assign humidity_q22_10      = sdp_reg[PostStages-1].hum;

    // ---------------- checks ----------------
    `ASSERT_IMPL(a_inval_forces_zero, out_valid && pressure_invalid, pressure_q24_8 == '0)
    `ASSERT_IMPL(a_hum_in_range, out_valid, humidity_q22_10 <= HumOutMax)
    `ASSERT_NEXT(a_accept_fills_entry, in_valid && in_ready, vld_reg[0])
    `ASSERT_IMPL(a_zero_flag_matches, vld_reg[FrontStages-1] && side10_reg.zero, md10_reg == '0)

endmodule
